// File: hdl/bni_pkg.sv
// Batch-norm inference package: payload structs, register codes, controller states.
// No dependencies; imported by every module of the block.
package bni_pkg;

  localparam int MaxChannels = 256;
  localparam int ChW = 8;
  localparam int PlaneLimit = 1048576;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_PLANE_SIZE    = 2'd1,
    REG_EPSILON       = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic              op;
    logic signed [15:0] sample_value;
    logic [7:0]        load_channel;
    logic signed [15:0] load_scale;
    logic signed [15:0] load_bias;
    logic signed [15:0] load_mean;
    logic [15:0]       load_variance;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [7:0]        out_channel;
    logic              last_of_sample;
    logic              saturated;
    logic              bad_channel;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQRT, ST_DIV, ST_STORE, ST_RD, ST_MUL1, ST_MUL2, ST_FIN, ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic store;
    logic rd;
    logic mul1;
    logic mul2;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic sqrt_done;
    logic div_done;
  } sts_t;

endpackage

// File: hdl/bni_ctrl.sv
// Controller state machine for batch-norm inference.
// Depends on bni_pkg; drives the datapath by cmd_t, reads sts_t.
module bni_ctrl import bni_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_RD;
      ST_RD:    state_d = sts_i.is_load ? ST_SQRT : ST_MUL1;
      ST_SQRT:  if (sts_i.sqrt_done) state_d = ST_DIV;
      ST_DIV:   if (sts_i.div_done) state_d = ST_STORE;
      ST_STORE: state_d = ST_IDLE;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_FIN;
      ST_FIN:   state_d = ST_OUT;
      ST_OUT:   if (!out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        cmd_o.sqrt_init = sts_i.is_load;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cmd_o.div_init = sts_i.sqrt_done;
      end
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_STORE: cmd_o.store = 1'b1;
      ST_MUL1:  cmd_o.mul1 = 1'b1;
      ST_MUL2:  cmd_o.mul2 = 1'b1;
      ST_FIN:   cmd_o.fin = 1'b1;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_out_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !sts_i.is_load) else $error("result for a load item");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("item taken while result pending");
`endif
endmodule

// File: hdl/bni_datapath.sv
// Datapath: channel tables, shared root/divide unit, multiply chain, counters.
// Depends on bni_pkg; sequenced by bni_ctrl through cmd_t.
module bni_datapath import bni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [8:0]  channel_count_i,
  input  logic [20:0] plane_size_i,
  input  logic [15:0] epsilon_i,
  output out_item_t   out_data_o
);
  in_item_t item_q;

  logic [15:0] scale_mem [MaxChannels];
  logic [15:0] bias_mem  [MaxChannels];
  logic [15:0] mean_mem  [MaxChannels];
  logic [32:0] inv_mem   [MaxChannels];
  logic        bad_mem   [MaxChannels];

  logic signed [15:0] scale_q, bias_q, mean_q;
  logic [32:0] inv_q;
  logic        bad_q;

  logic [ChW-1:0] chan_q;
  logic [19:0]    plane_q;

  // root: 42-bit radicand, 21 two-bit steps
  logic [41:0] rem_q, rad_q;
  logic [20:0] root_q;
  logic [4:0]  sq_cnt_q;
  // divide: 2^32 / root, 33 quotient bits
  logic [33:0] drem_q;
  logic [32:0] quo_q;
  logic [5:0]  dv_cnt_q;

  logic signed [17:0] diff_w;
  logic signed [51:0] prod1_q;
  logic signed [35:0] t_w;
  logic signed [51:0] prod2_q;
  out_item_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // table read for data items
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      scale_q <= scale_mem[chan_q];
      bias_q  <= bias_mem[chan_q];
      mean_q  <= mean_mem[chan_q];
      inv_q   <= inv_mem[chan_q];
      bad_q   <= bad_mem[chan_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      scale_mem[item_q.load_channel] <= item_q.load_scale;
      bias_mem[item_q.load_channel]  <= item_q.load_bias;
      mean_mem[item_q.load_channel]  <= item_q.load_mean;
      inv_mem[item_q.load_channel]   <= (root_q == '0) ? '0 : quo_q;
      bad_mem[item_q.load_channel]   <= (root_q == '0);
    end
  end

  // digit-by-digit square root
  logic [43:0] trial;
  logic [41:0] rem_sh;
  assign rem_sh = {rem_q[39:0], rad_q[41:40]};
  assign trial  = {2'b0, rem_sh} - {21'd0, root_q, 2'b01};
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q    <= {1'b0, ({1'b0, item_q.load_variance, 8'd0} + {9'd0, epsilon_i}), 16'd0};
      rem_q    <= '0;
      root_q   <= '0;
      sq_cnt_q <= '0;
    end else if (cmd_i.sqrt_step && !sts_o.sqrt_done) begin
      rad_q    <= {rad_q[39:0], 2'b00};
      sq_cnt_q <= sq_cnt_q + 5'd1;
      if (!trial[43]) begin
        rem_q  <= trial[41:0];
        root_q <= {root_q[19:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[19:0], 1'b0};
      end
    end
  end
  assign sts_o.sqrt_done = (sq_cnt_q == 5'd21);

  // restoring divide, dividend 2^32 fed bit by bit
  logic [33:0] dsh;
  logic [34:0] dsub;
  assign dsh  = {drem_q[32:0], (dv_cnt_q == 6'd0)};
  assign dsub = {1'b0, dsh} - {14'd0, root_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      drem_q   <= '0;
      quo_q    <= '0;
      dv_cnt_q <= '0;
    end else if (cmd_i.div_step && !sts_o.div_done) begin
      dv_cnt_q <= dv_cnt_q + 6'd1;
      if (!dsub[34]) begin
        drem_q <= dsub[33:0];
        quo_q  <= {quo_q[31:0], 1'b1};
      end else begin
        drem_q <= dsh;
        quo_q  <= {quo_q[31:0], 1'b0};
      end
    end
  end
  assign sts_o.div_done = (dv_cnt_q == 6'd33);
  assign sts_o.is_load  = item_q.op;

  // multiply chain; >>> floors
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) prod1_q <= 52'(diff_w) * $signed({19'd0, inv_q});
    if (cmd_i.mul2) prod2_q <= 52'(t_w) * 52'(scale_q);
  end
  assign diff_w = 18'(item_q.sample_value) - 18'(mean_q);
  assign t_w    = 36'(prod1_q >>> 16);

  logic signed [44:0] ysum;
  assign ysum = 45'(prod2_q >>> 8) + 45'(bias_q);

  logic last_s, pl_wrap;
  logic [8:0]  ch_lim;
  logic [20:0] pl_lim;
  always_comb begin
    ch_lim = (channel_count_i == 9'd0) ? 9'd1 :
             (channel_count_i > 9'(MaxChannels)) ? 9'(MaxChannels) : channel_count_i;
    pl_lim = (plane_size_i == 21'd0) ? 21'd1 :
             (plane_size_i > 21'(PlaneLimit)) ? 21'(PlaneLimit) : plane_size_i;
    pl_wrap = ({1'b0, plane_q} + 21'd1) >= pl_lim;
    last_s  = pl_wrap && (({1'b0, chan_q} + 9'd1) >= ch_lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      plane_q <= '0;
    end else if (cmd_i.fin) begin
      if (pl_wrap) begin
        plane_q <= '0;
        chan_q  <= last_s ? '0 : chan_q + 1'b1;
      end else begin
        plane_q <= plane_q + 20'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_q.out_channel    <= chan_q;
      res_q.last_of_sample <= last_s;
      res_q.bad_channel    <= bad_q;
      if (bad_q) begin
        res_q.out_value <= '0;
        res_q.saturated <= 1'b0;
      end else if (ysum > 45'sd32767) begin
        res_q.out_value <= 16'sh7fff;
        res_q.saturated <= 1'b1;
      end else if (ysum < -45'sd32768) begin
        res_q.out_value <= 16'sh8000;
        res_q.saturated <= 1'b1;
      end else begin
        res_q.out_value <= ysum[15:0];
        res_q.saturated <= 1'b0;
      end
    end
  end
  assign out_data_o = res_q;

endmodule

// File: hdl/batch_norm_inference.sv
// Batch-norm inference top level: config registers, controller, datapath.
// Data item: accepted, then table read, two multiply states and a finish state; result held until taken, then idle.
// Load item: table read, 21-step root, 33-step divide and table store before the next item is accepted.
// Rate is set by the controller walking one item at a time through the datapath.
// Reset: counters zero, channel_count 1, plane_size 1, epsilon 1; tables unset.
// Depends on bni_pkg, bni_ctrl, bni_datapath.
module batch_norm_inference import bni_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [8:0]  channel_count_q;
  logic [20:0] plane_size_q;
  logic [15:0] epsilon_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  // config writes; unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= 9'd1;
      plane_size_q    <= 21'd1;
      epsilon_q       <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index_i)
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[8:0];
        REG_PLANE_SIZE:    plane_size_q    <= cfg_data_i[20:0];
        REG_EPSILON:       epsilon_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bni_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sts_i(sts), .cmd_o(cmd)
  );

  bni_datapath u_dp (
    .clk_i, .rst_ni,
    .in_data_i, .cmd_i(cmd), .sts_o(sts),
    .channel_count_i(channel_count_q), .plane_size_i(plane_size_q),
    .epsilon_i(epsilon_q), .out_data_o
  );

endmodule
